/* hw/rtl/pdffd_pkg.sv */
// shared types, constants and codes for the pwm duty follower fan drive
package pdffd_pkg;

	// measurement counter and register widths
	localparam int CNT_W      = 16;
	localparam int TMO_W      = 16;
	localparam int CMPX_W     = (CNT_W > TMO_W) ? CNT_W : TMO_W;
	localparam int PCT_W      = 7;
	localparam int CMP_W      = 8;
	localparam int SUM_W      = PCT_W + 1;

	// divider: quotient never exceeds 100, so seven quotient bits suffice
	localparam int DIV_STEPS  = PCT_W;
	localparam int DCNT_W     = 3;
	localparam int DEN_W      = CNT_W + 1;
	localparam int NUM_W      = DEN_W + DIV_STEPS - 1;

	// 255*f/100 as f*(255*5243) >> 19, exact for f up to 127
	localparam int SCALE_SH   = 19;
	localparam int SCALE_KW   = 21;
	localparam int PROD_W     = SCALE_KW + PCT_W;
	localparam logic [SCALE_KW-1:0] SCALE_K = 21'd1336965;

	// stream and configuration port widths
	localparam int IN_W       = 8;
	localparam int OUT_W      = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_OFFSET   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PERCENT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PERCENT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_COUNT = 2'd3;

	// reset values
	localparam logic [PCT_W-1:0] RST_DUTY_OFFSET = 7'd20;
	localparam logic [PCT_W-1:0] RST_MIN_PERCENT = 7'd40;
	localparam logic [PCT_W-1:0] PCT_FULL        = 7'd100;
	localparam logic [PCT_W-1:0] PCT_ZERO        = 7'd0;
	localparam logic [TMO_W-1:0] RST_TIMEOUT     = 16'd32768;
	localparam logic [CMP_W-1:0] CMP_FULL        = 8'd255;

	// measurement sequencer phases
	typedef enum logic [1:0] {
		PH_HIGH_A = 2'd0,
		PH_LOW_A  = 2'd1,
		PH_HIGH_B = 2'd2,
		PH_LOW_B  = 2'd3
	} phase_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_CLAMP,
		S_SCALE,
		S_EMIT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic take;
		logic mul_ld;
		logic div_step;
		logic clamp_ld;
		logic scale_ld;
		logic emit;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic fin;
		logic need_div;
		logic div_last;
	} sts_t;

endpackage

/* hw/rtl/pdffd_ctrl.sv */
// controller state machine: handshakes and sequencing of the finish path
module pdffd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  pdffd_pkg::sts_t sts,
	output pdffd_pkg::cmd_t cmd
);
	import pdffd_pkg::*;

	state_t state_q, state_d;
	logic   ov_q;
	logic   take;

	// input is taken only when idle and the output slot frees up
	assign s_tready = (state_q == S_IDLE) && (!ov_q || m_tready);
	assign take     = s_tvalid && s_tready;
	assign m_tvalid = ov_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take && sts.fin) begin
					state_d = sts.need_div ? S_MUL : S_CLAMP;
				end
			end
			S_MUL:   state_d = S_DIV;
			S_DIV: begin
				if (sts.div_last) begin
					state_d = S_CLAMP;
				end
			end
			S_CLAMP: state_d = S_SCALE;
			S_SCALE: state_d = S_EMIT;
			S_EMIT:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd          = '0;
		cmd.take     = take;
		unique case (state_q)
			S_MUL:   cmd.mul_ld   = 1'b1;
			S_DIV:   cmd.div_step = 1'b1;
			S_CLAMP: cmd.clamp_ld = 1'b1;
			S_SCALE: cmd.scale_ld = 1'b1;
			S_EMIT:  cmd.emit     = 1'b1;
			default: cmd.take     = take;
		endcase
	end

	// state and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((take && !sts.fin) || (state_q == S_EMIT)) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/pdffd_dp.sv */
// datapath: config registers, phase counters, divider, clamp, scale and pwm counter
module pdffd_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pin_level,
	input  logic                             cfg_we,
	input  logic [pdffd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdffd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  pdffd_pkg::cmd_t                  cmd,
	output pdffd_pkg::sts_t                  sts,
	output logic [pdffd_pkg::OUT_W-1:0]      out_word
);
	import pdffd_pkg::*;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// configuration
	logic [PCT_W-1:0] off_q, min_q, max_q;
	logic [TMO_W-1:0] tmo_q;

	// measurement state
	phase_t           phase_q;
	logic [CNT_W-1:0] hc_q, lc_q;
	logic [PCT_W-1:0] last_q, fan_q;
	logic [CMP_W-1:0] compare_q, pwm_cnt_q;

	// finish path
	logic              pwm_hold_q;
	logic [CNT_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  rem_q, dsr_q;
	logic [PCT_W-1:0]  pct_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [PROD_W-1:0] prod_q;
	logic [OUT_W-1:0]  out_q;

	// combinational
	logic [CNT_W-1:0]          hb, lb;
	logic                      hto, lto, fix_high;
	logic                      pwm_now;
	logic [SUM_W-1:0]          sum;
	logic [PCT_W-1:0]          fan_new;
	logic [PROD_W-SCALE_SH-1:0] cmp_wide;
	logic [CMP_W-1:0]          cmp_new;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= RST_DUTY_OFFSET;
			min_q <= RST_MIN_PERCENT;
			max_q <= PCT_FULL;
			tmo_q <= RST_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DUTY_OFFSET:   off_q <= cfg_wdata[PCT_W-1:0];
				REG_MIN_PERCENT:   min_q <= cfg_wdata[PCT_W-1:0];
				REG_MAX_PERCENT:   max_q <= cfg_wdata[PCT_W-1:0];
				REG_TIMEOUT_COUNT: tmo_q <= cfg_wdata[TMO_W-1:0];
				default:           tmo_q <= tmo_q;
			endcase
		end
	end

	// saturating count bump and timeout test
	always_comb begin
		hb  = (hc_q == CNT_MAX) ? hc_q : hc_q + 1'b1;
		lb  = (lc_q == CNT_MAX) ? lc_q : lc_q + 1'b1;
		hto = (CMPX_W'(hb) >= CMPX_W'(tmo_q)) || (hb == CNT_MAX);
		lto = (CMPX_W'(lb) >= CMPX_W'(tmo_q)) || (lb == CNT_MAX);
	end

	// finish decode for the current sample
	always_comb begin
		sts.fin      = 1'b0;
		sts.need_div = 1'b0;
		fix_high     = 1'b0;
		case (phase_q)
			PH_HIGH_A, PH_HIGH_B: begin
				sts.fin  = hto;
				fix_high = 1'b1;
			end
			PH_LOW_A: sts.fin = lto;
			default: begin
				sts.fin      = lto || pin_level;
				sts.need_div = !lto && pin_level;
			end
		endcase
		sts.div_last = (dcnt_q == DCNT_W'(DIV_STEPS - 1));
	end

	assign pwm_now = (pwm_cnt_q <= compare_q);

	// phase sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HIGH_A;
			hc_q      <= '0;
			lc_q      <= '0;
			pwm_cnt_q <= '0;
		end else if (cmd.take) begin
			pwm_cnt_q <= pwm_cnt_q + 1'b1;
			if (sts.fin) begin
				phase_q <= PH_HIGH_A;
				hc_q    <= '0;
				lc_q    <= '0;
			end else begin
				case (phase_q)
					PH_HIGH_A, PH_HIGH_B: begin
						hc_q <= hb;
						if (!pin_level) begin
							phase_q <= phase_t'(phase_q + 2'd1);
						end
					end
					PH_LOW_A: begin
						if (pin_level) begin
							phase_q <= PH_HIGH_B;
							hc_q    <= '0;
							lc_q    <= '0;
						end else begin
							lc_q <= lb;
						end
					end
					default: lc_q <= lb;
				endcase
			end
		end
	end

	// clamp of measured plus offset, minimum tested first
	always_comb begin
		sum = SUM_W'(pct_q) + SUM_W'(off_q);
		if (sum < SUM_W'(min_q)) begin
			fan_new = min_q;
		end else if (sum > SUM_W'(max_q)) begin
			fan_new = max_q;
		end else begin
			fan_new = sum[PCT_W-1:0];
		end
	end

	// compare value with saturation at full scale
	always_comb begin
		cmp_wide = prod_q[PROD_W-1:SCALE_SH];
		cmp_new  = (cmp_wide > (PROD_W-SCALE_SH)'(CMP_FULL)) ? CMP_FULL
			: cmp_wide[CMP_W-1:0];
	end

	// divider operands, shift-subtract quotient and scale product
	always_ff @(posedge clk) begin
		if (cmd.take && sts.fin) begin
			pwm_hold_q <= pwm_now;
			num_q      <= hc_q;
			den_q      <= DEN_W'(hc_q) + DEN_W'(lb);
			pct_q      <= fix_high ? PCT_FULL : PCT_ZERO;
		end
		if (cmd.mul_ld) begin
			rem_q  <= NUM_W'(num_q) * NUM_W'(PCT_FULL);
			dsr_q  <= {den_q, {(DIV_STEPS-1){1'b0}}};
			pct_q  <= '0;
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			if (rem_q >= dsr_q) begin
				rem_q <= rem_q - dsr_q;
				pct_q <= {pct_q[PCT_W-2:0], 1'b1};
			end else begin
				pct_q <= {pct_q[PCT_W-2:0], 1'b0};
			end
			dsr_q  <= dsr_q >> 1;
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.scale_ld) begin
			prod_q <= PROD_W'(fan_q) * PROD_W'(SCALE_K);
		end
	end

	// measurement results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= PCT_FULL;
			fan_q     <= PCT_FULL;
			compare_q <= CMP_FULL;
		end else begin
			if (cmd.clamp_ld) begin
				last_q <= pct_q;
				fan_q  <= fan_new;
			end
			if (cmd.emit) begin
				compare_q <= cmp_new;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.take && !sts.fin) begin
			out_q <= {compare_q, fan_q, last_q, 1'b0, pwm_now};
		end else if (cmd.emit) begin
			out_q <= {cmp_new, fan_q, last_q, 1'b1, pwm_hold_q};
		end
	end

	assign out_word = out_q;

endmodule

/* hw/rtl/pwm_duty_follower_fan_drive_unit.sv */
// top level of the pwm duty follower fan drive
// Each input word is one sample tick of a pwm input level; each produces
// exactly one output word with the regenerated pwm level, a done flag and the
// measured percent, fan percent and compare value after that tick.
// A four-phase sequencer measures the input duty; on a finished measurement
// the fan percent is measured plus offset, clamped to min and max, and the
// compare value is 255*fan/100.
// A tick that finishes nothing yields its word in the cycle after it is
// accepted, one word per cycle while the receiver takes them. A timeout
// tick passes through clamp, scale and emit; a tick that completes a
// measurement passes through the multiply, the seven-step shift-subtract
// divider, clamp, scale and emit. s_tready stays low while that work runs.
// The output word sits in a register; when the receiver stalls, the held word
// stays and one further input word may not be taken until it leaves.
// Config writes take effect on the next edge; the block does not gate them,
// so make them while idle. Reset: config to defaults (offset 20, min 40, max
// 100, timeout 32768); measured and fan 100 percent, compare 255 (full duty).
module pwm_duty_follower_fan_drive_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pdffd_pkg::IN_W-1:0]       s_tdata,   // [0] pin_level, rest zero
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] pwm_out, [1] measure_done, [8:2] measured_percent,
	// [15:9] fan_percent, [23:16] compare_value
	output logic [pdffd_pkg::OUT_W-1:0]      m_tdata,
	input  logic                             cfg_we,
	input  logic [pdffd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdffd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import pdffd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing and handshakes
	pdffd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// measurement and arithmetic
	pdffd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.pin_level (s_tdata[0]),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_word  (m_tdata)
	);

endmodule
